// ===== rtl/bounded_life_automaton_engine_assert.svh =====
// Assertion macros for the life engine checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef BOUNDED_LIFE_AUTOMATON_ENGINE_ASSERT_SVH
`define BOUNDED_LIFE_AUTOMATON_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define BLAE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blae assertion failed");

// Next-cycle implication.
`define BLAE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blae assertion failed");

`endif

// ===== rtl/blae_pkg.sv =====
// Shared types and constants of the bounded life engine.
// No dependencies; every other file but the assertion header takes names from here.
`timescale 1ns / 1ps

package blae_pkg;

  localparam int MaxRowsDef = 64;
  localparam int MaxColsDef = 64;
  localparam int CfgW       = 7;
  localparam int CfgIdxW    = 1;
  localparam int CmdW       = 2;
  localparam int CoordW     = 6;
  localparam int StatusW    = 2;
  localparam int RowsReset  = 64;
  localparam int ColsReset  = 64;
  localparam int LiveBirth  = 3;
  localparam int LiveKeep   = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BOTH_OUT = 2'd1,
    ST_ROW_OUT  = 2'd2,
    ST_COL_OUT  = 2'd3
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS = 1'd0,
    CFG_COLS = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ZERO,
    WR_SET
  } wr_sel_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_SET_RD,
    S_SET_WR,
    S_READ_RD,
    S_READ_CAP,
    S_STEP,
    S_STEP_DRAIN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    item_load;
    logic    k_zero;
    logic    k_inc;
    logic    step_issue;
    wr_sel_t wr_sel;
    logic    alive_cap;
    logic    res_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic step_last;
  } ctl_stat_t;

endpackage

// ===== rtl/blae_item_if.sv =====
// Command channel of the life engine: valid/ready plus one command item.
// Depends on blae_pkg for field widths.
`timescale 1ns / 1ps

interface blae_item_if;
  logic                          valid;
  logic                          ready;
  logic [blae_pkg::CmdW-1:0]     cmd;
  logic [blae_pkg::CoordW-1:0]   cell_row;
  logic [blae_pkg::CoordW-1:0]   cell_col;

  modport source (output valid, output cmd, output cell_row, output cell_col, input ready);
  modport sink   (input valid, input cmd, input cell_row, input cell_col, output ready);
endinterface

// ===== rtl/blae_result_if.sv =====
// Result channel of the life engine: valid/ready plus status and cell state.
// Depends on blae_pkg for field widths.
`timescale 1ns / 1ps

interface blae_result_if;
  logic                           valid;
  logic                           ready;
  logic [blae_pkg::StatusW-1:0]   status;
  logic                           cell_alive;

  modport source (output valid, output status, output cell_alive, input ready);
  modport sink   (input valid, input status, input cell_alive, output ready);
endinterface

// ===== rtl/blae_ctrl.sv =====
// Sequencer of the life engine: command decode, row sweeps, result handoff.
// Depends on blae_pkg; drives blae_datapath through ctl_cmd_t.
`timescale 1ns / 1ps

module blae_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic [blae_pkg::CmdW-1:0]  item_cmd,
  output logic                       item_ready,
  output logic                       result_valid,
  input  logic                       result_ready,
  input  blae_pkg::ctl_stat_t        stat,
  output blae_pkg::ctl_cmd_t         ctl
);

  blae_pkg::state_t state, state_next;
  logic             out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blae_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.wr_sel = blae_pkg::WR_NONE;
    item_ready = 1'b0;
    unique case (state)
      blae_pkg::S_INIT: begin
        ctl.wr_sel = blae_pkg::WR_ZERO;
        ctl.k_inc  = 1'b1;
        if (stat.clr_last) begin
          state_next = blae_pkg::S_IDLE;
        end
      end
      blae_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          ctl.item_load = 1'b1;
          ctl.k_zero    = 1'b1;
          unique case (blae_pkg::cmd_t'(item_cmd))
            blae_pkg::CMD_CLEAR: state_next = blae_pkg::S_CLEAR;
            blae_pkg::CMD_SET:   state_next = blae_pkg::S_SET_RD;
            blae_pkg::CMD_STEP:  state_next = blae_pkg::S_STEP;
            blae_pkg::CMD_READ:  state_next = blae_pkg::S_READ_RD;
            default:             state_next = blae_pkg::S_IDLE;
          endcase
        end
      end
      blae_pkg::S_CLEAR: begin
        ctl.wr_sel = blae_pkg::WR_ZERO;
        ctl.k_inc  = 1'b1;
        if (stat.clr_last) begin
          state_next = blae_pkg::S_RESP;
        end
      end
      blae_pkg::S_SET_RD: begin
        state_next = blae_pkg::S_SET_WR;
      end
      blae_pkg::S_SET_WR: begin
        ctl.wr_sel = blae_pkg::WR_SET;
        state_next = blae_pkg::S_RESP;
      end
      blae_pkg::S_READ_RD: begin
        state_next = blae_pkg::S_READ_CAP;
      end
      blae_pkg::S_READ_CAP: begin
        ctl.alive_cap = 1'b1;
        state_next    = blae_pkg::S_RESP;
      end
      blae_pkg::S_STEP: begin
        ctl.step_issue = 1'b1;
        if (stat.step_last) begin
          state_next = blae_pkg::S_STEP_DRAIN;
        end
      end
      blae_pkg::S_STEP_DRAIN: begin
        state_next = blae_pkg::S_RESP;
      end
      blae_pkg::S_RESP: begin
        if (!out_valid || result_ready) begin
          ctl.res_load = 1'b1;
          state_next   = blae_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = blae_pkg::S_IDLE;
      end
    endcase
  end

  assign result_valid = out_valid;

endmodule

// ===== rtl/blae_datapath.sv =====
// Datapath of the life engine: grid row memory, three-row window, B3/S23 logic,
// active-size registers, item and result registers. Depends on blae_pkg.
`timescale 1ns / 1ps

module blae_datapath #(
  parameter int MAX_ROWS = blae_pkg::MaxRowsDef,
  parameter int MAX_COLS = blae_pkg::MaxColsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [blae_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [blae_pkg::CfgW-1:0]     cfg_data,
  input  logic [blae_pkg::CmdW-1:0]     item_cmd,
  input  logic [blae_pkg::CoordW-1:0]   item_row,
  input  logic [blae_pkg::CoordW-1:0]   item_col,
  input  blae_pkg::ctl_cmd_t            ctl,
  output blae_pkg::ctl_stat_t           stat,
  output logic [blae_pkg::StatusW-1:0]  res_status,
  output logic                          res_alive
);

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int KW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int NCW = $clog2(MAX_COLS + 1);
  localparam int RowsRst = (blae_pkg::RowsReset > MAX_ROWS) ? MAX_ROWS : blae_pkg::RowsReset;
  localparam int ColsRst = (blae_pkg::ColsReset > MAX_COLS) ? MAX_COLS : blae_pkg::ColsReset;

  logic [KW-1:0]           n_rows;
  logic [NCW-1:0]          n_cols;
  logic [KW-1:0]           rows_sat;
  logic [NCW-1:0]          cols_sat;

  blae_pkg::status_t       st_in;
  blae_pkg::status_t       st_q;
  logic [blae_pkg::CoordW-1:0] row_q;
  logic [blae_pkg::CoordW-1:0] col_q;
  logic                    alive_q;
  logic                    row_out;
  logic                    col_out;

  logic [KW-1:0]           k;
  logic [KW-1:0]           proc_k;
  logic [KW-1:0]           proc_km1;
  logic                    proc_valid;
  logic [MAX_COLS-1:0]     w_prev;
  logic [MAX_COLS-1:0]     w_cur;

  logic [MAX_COLS-1:0]     mem [MAX_ROWS];
  logic [MAX_COLS-1:0]     rd;
  logic [AW-1:0]           rd_addr;
  logic                    we;
  logic [AW-1:0]           wa;
  logic [MAX_COLS-1:0]     wd;

  logic [CW-1:0]           col_idx;
  logic [MAX_COLS-1:0]     col_bit;
  logic [MAX_COLS-1:0]     col_en;
  logic                    nxt_ok;
  logic [MAX_COLS-1:0]     p_row;
  logic [MAX_COLS-1:0]     q_row;
  logic [MAX_COLS-1:0]     n_row;
  logic [MAX_COLS+1:0]     pe;
  logic [MAX_COLS+1:0]     qe;
  logic [MAX_COLS+1:0]     ne;
  logic [3:0]              nbr_cnt [MAX_COLS];
  logic [MAX_COLS-1:0]     life;
  logic [MAX_COLS-1:0]     new_row;

  // Active size, saturated to the store.
  always_comb begin
    if (32'(cfg_data) > 32'(MAX_ROWS)) begin
      rows_sat = KW'(MAX_ROWS);
    end else begin
      rows_sat = KW'(cfg_data);
    end
    if (32'(cfg_data) > 32'(MAX_COLS)) begin
      cols_sat = NCW'(MAX_COLS);
    end else begin
      cols_sat = NCW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_rows <= KW'(RowsRst);
      n_cols <= NCW'(ColsRst);
    end else if (cfg_we) begin
      unique case (blae_pkg::cfg_reg_t'(cfg_index))
        blae_pkg::CFG_ROWS: n_rows <= rows_sat;
        blae_pkg::CFG_COLS: n_cols <= cols_sat;
        default: ;
      endcase
    end
  end

  // Range check at item load.
  always_comb begin
    row_out = 32'(item_row) >= 32'(n_rows);
    col_out = 32'(item_col) >= 32'(n_cols);
    st_in   = blae_pkg::ST_OK;
    if (blae_pkg::cmd_t'(item_cmd) == blae_pkg::CMD_SET ||
        blae_pkg::cmd_t'(item_cmd) == blae_pkg::CMD_READ) begin
      priority if (row_out && col_out) begin
        st_in = blae_pkg::ST_BOTH_OUT;
      end else if (row_out) begin
        st_in = blae_pkg::ST_ROW_OUT;
      end else if (col_out) begin
        st_in = blae_pkg::ST_COL_OUT;
      end else begin
        st_in = blae_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      st_q  <= st_in;
      row_q <= item_row;
      col_q <= item_col;
    end
  end

  assign col_idx = CW'(col_q);

  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      alive_q <= 1'b0;
    end else if (ctl.alive_cap) begin
      alive_q <= (st_q == blae_pkg::ST_OK) && rd[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res_status <= st_q;
      res_alive  <= alive_q;
    end
  end

  // Row counter and step pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= '0;
      proc_valid <= 1'b0;
    end else begin
      proc_valid <= ctl.step_issue;
      if (ctl.k_zero) begin
        k <= '0;
      end else if (ctl.k_inc || ctl.step_issue) begin
        k <= k + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_k <= k;
    if (ctl.k_zero) begin
      w_prev <= '0;
      w_cur  <= '0;
    end else if (proc_valid) begin
      w_prev <= w_cur;
      w_cur  <= rd;
    end
  end

  assign stat.clr_last  = (k == KW'(MAX_ROWS - 1));
  assign stat.step_last = (k == n_rows);

  // B3/S23 on the window: rows above, at and below the row being written.
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_en[c] = (NCW'(c) < n_cols);
    end
  end

  assign nxt_ok = proc_k < n_rows;
  assign p_row  = w_prev & col_en;
  assign q_row  = w_cur & col_en;
  assign n_row  = nxt_ok ? (rd & col_en) : '0;
  assign pe     = {1'b0, p_row, 1'b0};
  assign qe     = {1'b0, q_row, 1'b0};
  assign ne     = {1'b0, n_row, 1'b0};

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      nbr_cnt[c] = 4'(pe[c]) + 4'(pe[c+1]) + 4'(pe[c+2]) +
                   4'(qe[c]) + 4'(qe[c+2]) +
                   4'(ne[c]) + 4'(ne[c+1]) + 4'(ne[c+2]);
      life[c]    = (nbr_cnt[c] == 4'(blae_pkg::LiveBirth)) ||
                   (q_row[c] && nbr_cnt[c] == 4'(blae_pkg::LiveKeep));
    end
  end

  assign new_row  = (life & col_en) | (w_cur & ~col_en);
  assign proc_km1 = proc_k - KW'(1);

  always_comb begin
    col_bit          = '0;
    col_bit[col_idx] = 1'b1;
  end

  // Memory port selection.
  always_comb begin
    we = 1'b0;
    wa = AW'(row_q);
    wd = '0;
    priority if (proc_valid && proc_k != '0) begin
      we = 1'b1;
      wa = proc_km1[AW-1:0];
      wd = new_row;
    end else begin
      unique case (ctl.wr_sel)
        blae_pkg::WR_ZERO: begin
          we = 1'b1;
          wa = k[AW-1:0];
          wd = '0;
        end
        blae_pkg::WR_SET: begin
          we = (st_q == blae_pkg::ST_OK);
          wa = AW'(row_q);
          wd = rd | col_bit;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  assign rd_addr = ctl.step_issue ? k[AW-1:0] : AW'(row_q);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[rd_addr];
  end

endmodule

// ===== rtl/bounded_life_automaton_engine.sv =====
// Top level of the bounded life engine; joins blae_ctrl and blae_datapath.
// Depends on blae_pkg, blae_item_if and blae_result_if.
`timescale 1ns / 1ps

// Bounded B3/S23 life engine. The grid sits in a memory of MAX_ROWS rows,
// MAX_COLS cells each, read and written one row per cycle. After reset the
// block sweeps that memory to all dead and holds item.ready low meanwhile;
// configuration writes are taken at any time. One item is in work at a time
// and gives exactly one result. Set reads the addressed row and writes it
// back with the cell set, read captures the cell from the row it reads, clear
// sweeps every row to dead, and a generation step streams the active rows
// through the single row port and a three-row window. A finished result waits
// in an output register, so the next item may transfer while it is not yet
// taken.
module bounded_life_automaton_engine #(
  parameter int MAX_ROWS = blae_pkg::MaxRowsDef,
  parameter int MAX_COLS = blae_pkg::MaxColsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  blae_item_if.sink                     item,
  blae_result_if.source                 result,
  input  logic                          cfg_we,
  input  logic [blae_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [blae_pkg::CfgW-1:0]     cfg_data
);

  blae_pkg::ctl_cmd_t  ctl;
  blae_pkg::ctl_stat_t stat;

  blae_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_cmd     (item.cmd),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat         (stat),
    .ctl          (ctl)
  );

  blae_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_cmd   (item.cmd),
    .item_row   (item.cell_row),
    .item_col   (item.cell_col),
    .ctl        (ctl),
    .stat       (stat),
    .res_status (result.status),
    .res_alive  (result.cell_alive)
  );

endmodule

// ===== rtl/blae_checker.sv =====
// Port-level checks of the life engine, bound to the top level.
// Depends on blae_pkg and bounded_life_automaton_engine_assert.svh.
`timescale 1ns / 1ps
`include "bounded_life_automaton_engine_assert.svh"

module blae_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [blae_pkg::StatusW-1:0]  result_status,
  input logic                          result_alive
);

  `BLAE_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid)
  `BLAE_ASSERT_NXT(a_result_stable, result_valid && !result_ready, $stable(result_status) && $stable(result_alive))
  `BLAE_ASSERT_IMP(a_alive_only_ok, result_valid && result_alive, result_status == blae_pkg::ST_OK)
  `BLAE_ASSERT_NXT(a_busy_after_transfer, item_valid && item_ready, !item_ready)

endmodule

bind bounded_life_automaton_engine blae_checker u_blae_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_status (result.status),
  .result_alive  (result.cell_alive)
);

// ===== verif/life_grid_checker.sv =====
// Checker for the bounded life engine: predicts each command's outcome and compares results.
// Depends on blae_pkg, blae_item_if and blae_result_if; watches the channels and config port.
`timescale 1ns / 1ps

module life_grid_checker (
  input  logic                          clk,
  input  logic                          rst,
  blae_item_if                          item,
  blae_result_if                        result,
  input  logic                          cfg_we,
  input  logic [blae_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [blae_pkg::CfgW-1:0]     cfg_data,
  output int                            pending,
  output int                            fails
);
  import blae_pkg::*;

  typedef struct packed {
    status_t status;
    logic    alive;
  } outcome_t;

  logic [MaxColsDef-1:0] cells [MaxRowsDef];
  logic [CfgW-1:0]       rows_reg;
  logic [CfgW-1:0]       cols_reg;
  outcome_t              outcome_q [$];
  int                    fail_count = 0;

  function automatic int clamp_size(logic [CfgW-1:0] v, int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic status_t range_check(logic [CoordW-1:0] r, logic [CoordW-1:0] c);
    logic row_out;
    logic col_out;
    row_out = int'(r) >= clamp_size(rows_reg, MaxRowsDef);
    col_out = int'(c) >= clamp_size(cols_reg, MaxColsDef);
    if (row_out && col_out) return ST_BOTH_OUT;
    if (row_out) return ST_ROW_OUT;
    if (col_out) return ST_COL_OUT;
    return ST_OK;
  endfunction

  function automatic void advance_generation();
    logic [MaxColsDef-1:0] nxt [MaxRowsDef];
    int nr, nc, n, y, x;
    nr = clamp_size(rows_reg, MaxRowsDef);
    nc = clamp_size(cols_reg, MaxColsDef);
    nxt = cells;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            y = r + dr;
            x = c + dc;
            if ((dr != 0 || dc != 0) && y >= 0 && y < nr && x >= 0 && x < nc)
              n += cells[y][x];
          end
        end
        nxt[r][c] = (n == LiveBirth) || (cells[r][c] && n == LiveKeep);
      end
    end
    cells = nxt;
  endfunction

  function automatic outcome_t predict_outcome(cmd_t op, logic [CoordW-1:0] r,
                                               logic [CoordW-1:0] c);
    outcome_t o;
    o.status = ST_OK;
    o.alive  = 1'b0;
    case (op)
      CMD_CLEAR: begin
        foreach (cells[i]) cells[i] = '0;
      end
      CMD_SET: begin
        o.status = range_check(r, c);
        if (o.status == ST_OK) cells[r][c] = 1'b1;
      end
      CMD_STEP: begin
        advance_generation();
      end
      default: begin
        o.status = range_check(r, c);
        if (o.status == ST_OK) o.alive = cells[r][c];
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      foreach (cells[i]) cells[i] = '0;
      rows_reg = CfgW'(RowsReset);
      cols_reg = CfgW'(ColsReset);
      outcome_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ROWS: rows_reg = cfg_data;
          CFG_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        outcome_q.push_back(predict_outcome(cmd_t'(item.cmd), item.cell_row, item.cell_col));
      if (result.valid && result.ready) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          $error("result transfer with no command outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (result.status !== want.status) begin
            fail_count++;
            $error("status mismatch: expected %0d, actual %0d", want.status, result.status);
          end
          if (result.cell_alive !== want.alive) begin
            fail_count++;
            $error("cell_alive mismatch: expected %0d, actual %0d", want.alive,
                   result.cell_alive);
          end
        end
      end
    end
    pending <= outcome_q.size();
    fails   <= fail_count;
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the life engine bench: clock, reset, command stimulus, result back-pressure, verdict.
// Depends on blae_pkg, the two channel interfaces, life_grid_checker and the engine itself.
`timescale 1ns / 1ps

module testbench;
  import blae_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 80;
  localparam int PhaseItems    = 70;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  int                 pending;
  int                 fails;
  int                 rows_cfg = RowsReset;
  int                 cols_cfg = ColsReset;
  bit                 idle_on = 1'b1;
  int                 n_cmd [4] = '{0, 0, 0, 0};
  int                 n_sizes = 0;

  blae_item_if   item_ch ();
  blae_result_if result_ch ();

  bounded_life_automaton_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  life_grid_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fails     (fails)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : result_sink
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    stall = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        taken++;
        // hold off long enough to back up the command side
        if (taken % 400 == 150) stall = 300;
      end
      if (stall != 0) begin
        stall--;
        result_ch.ready <= 1'b0;
      end else if ((taken / 50) % 2 == 0 || $urandom_range(0, 3) != 0) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 49) : $urandom_range(0, 2);
      end
    end
  end

  function automatic int span(int v);
    return (v > MaxRowsDef) ? MaxRowsDef : v;
  endfunction

  function automatic int pick(int extent);
    return (extent == 0) ? int'($urandom_range(0, 63)) : int'($urandom_range(0, extent - 1));
  endfunction

  function automatic int jitter(int base);
    return (base + int'($urandom_range(0, 6)) - 3) & 63;
  endfunction

  task automatic send(cmd_t op, int r, int c);
    int gap;
    item_ch.valid    <= 1'b1;
    item_ch.cmd      <= op;
    item_ch.cell_row <= r[CoordW-1:0];
    item_ch.cell_col <= c[CoordW-1:0];
    do @(posedge clk); while (!item_ch.ready);
    n_cmd[op]++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_size(int rows, int cols);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows[CfgW-1:0];
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data  <= cols[CfgW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_cfg = rows;
    cols_cfg = cols;
    n_sizes++;
  endtask

  // mostly clear, seed a cluster, then alternate generations with reads around it
  task automatic run_episodes(int count);
    int sent, r0, c0, ar, ac;
    ar = span(rows_cfg);
    ac = span(cols_cfg);
    sent = 0;
    while (sent < count) begin
      r0 = pick(ar);
      c0 = pick(ac);
      if ($urandom_range(0, 3) != 0) begin
        send(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        sent++;
      end
      repeat ($urandom_range(4, 20)) begin
        send(CMD_SET, jitter(r0), jitter(c0));
        sent++;
      end
      repeat ($urandom_range(2, 6)) begin
        send(CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63));
        sent++;
        repeat ($urandom_range(1, 4)) begin
          send(CMD_READ, jitter(r0), jitter(c0));
          sent++;
        end
        if ($urandom_range(0, 4) == 0) begin
          send(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63));
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int row_list [10] = '{8, 1, 0, 127, 3, 64, 1, 2, 20, 64};
    int col_list [10] = '{8, 1, 20, 127, 3, 1, 64, 64, 0, 64};
    item_ch.valid    = 1'b0;
    item_ch.cmd      = CMD_CLEAR;
    item_ch.cell_row = '0;
    item_ch.cell_col = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_ROWS;
    cfg_data         = '0;
    rst              = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // corners, a blinker away from the border of the full grid
    send(CMD_CLEAR, 0, 0);
    send(CMD_SET, 0, 0);
    send(CMD_SET, 63, 63);
    send(CMD_SET, 0, 63);
    send(CMD_READ, 63, 63);
    send(CMD_READ, 0, 0);
    send(CMD_READ, 32, 17);
    send(CMD_SET, 10, 10);
    send(CMD_SET, 10, 11);
    send(CMD_SET, 10, 12);
    send(CMD_STEP, 63, 63);
    send(CMD_READ, 9, 11);
    send(CMD_READ, 10, 10);
    send(CMD_READ, 11, 11);
    send(CMD_STEP, 0, 0);
    send(CMD_READ, 10, 10);

    // small area: each out-of-range axis, a blinker cut by the border
    program_size(4, 4);
    send(CMD_SET, 4, 0);
    send(CMD_SET, 0, 4);
    send(CMD_READ, 63, 63);
    send(CMD_SET, 0, 1);
    send(CMD_SET, 0, 2);
    send(CMD_SET, 0, 3);
    send(CMD_STEP, 0, 0);
    send(CMD_READ, 1, 2);
    program_size(64, 64);
    send(CMD_READ, 10, 11);

    for (int k = 0; k < 12; k++) begin
      if (k < 10)
        program_size(row_list[k], col_list[k]);
      else
        program_size($urandom_range(0, 127), $urandom_range(0, 127));
      idle_on = (k % 4 != 3);
      run_episodes(PhaseItems);
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    $display("Checked %0d commands: %0d clear, %0d set, %0d step, %0d read.",
             n_cmd[0] + n_cmd[1] + n_cmd[2] + n_cmd[3], n_cmd[CMD_CLEAR], n_cmd[CMD_SET],
             n_cmd[CMD_STEP], n_cmd[CMD_READ]);
    $display("Grid sizes programmed: %0d, empty, single-cell and saturated areas among them.",
             n_sizes);
    if (fails == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
